[hdl/sfcp_pkg.sv]
`timescale 1ns / 1ps

package sfcp_pkg;

  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [3:0] FIRST_POS  = 4'd1;
  localparam logic [3:0] LAST_POS   = 4'd8;
  localparam logic [3:0] IDLE_POS   = 4'd9;
  localparam logic [3:0] HI_POS_UPLOAD = 4'd4;
  localparam logic [3:0] HI_POS_ANSWER = 4'd2;

  // Answer mode codes.
  localparam logic MODE_UPLOAD = 1'b0;
  localparam logic MODE_ANSWER = 1'b1;

  typedef struct packed {
    logic        valid;
    logic [15:0] concentration;
    logic        ready_toggle;
  } sfcp_result_t;

endpackage

[hdl/sfcp_frame.sv]
`timescale 1ns / 1ps

module sfcp_frame import sfcp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [7:0]   rx_byte,
  input  logic         answer_mode,
  input  logic         hold,
  output logic         in_stall,
  output logic         stage_full,
  output sfcp_result_t res
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       step;

  logic [3:0] byte_position, byte_position_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] value_high, value_high_next;
  logic [7:0] value_low, value_low_next;
  logic       toggle_flag, toggle_flag_next;
  logic       hit;
  logic [3:0] hi_pos;

  assign in_stall   = s1_valid & hold;
  assign stage_full = s1_valid;
  assign step       = s1_valid & ~hold;

  // Input register: load whenever the stage is free to move.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    value_high_next    = value_high;
    value_low_next     = value_low;
    toggle_flag_next   = toggle_flag;
    hit                = 1'b0;
    hi_pos = (answer_mode == MODE_ANSWER) ? HI_POS_ANSWER : HI_POS_UPLOAD;
    if (s1_byte == START_BYTE) begin
      byte_position_next = FIRST_POS;
      running_sum_next   = 8'd0;
    end else if (byte_position == 4'd0 || byte_position > LAST_POS) begin
      // idle: drop the byte
    end else if (byte_position < LAST_POS) begin
      running_sum_next = running_sum + s1_byte;
      if (byte_position == hi_pos) begin
        value_high_next = s1_byte;
      end else if (byte_position == hi_pos + 4'd1) begin
        value_low_next = s1_byte;
      end
      byte_position_next = byte_position + 4'd1;
    end else begin
      byte_position_next = IDLE_POS;
      if (s1_byte == 8'(8'd0 - running_sum)) begin
        hit              = 1'b1;
        toggle_flag_next = ~toggle_flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= IDLE_POS;
      running_sum   <= 8'd0;
      value_high    <= 8'd0;
      value_low     <= 8'd0;
      toggle_flag   <= 1'b0;
    end else if (step) begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      value_high    <= value_high_next;
      value_low     <= value_low_next;
      toggle_flag   <= toggle_flag_next;
    end
  end

  assign res.valid         = step & hit;
  assign res.concentration = {value_high, value_low};
  assign res.ready_toggle  = toggle_flag_next;

endmodule

[hdl/sfcp_out_reg.sv]
`timescale 1ns / 1ps

module sfcp_out_reg import sfcp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  sfcp_result_t res,
  input  logic         out_stall,
  output logic         out_valid,
  output logic [15:0]  concentration,
  output logic         ready_toggle,
  output logic         hold
);

  // A held result blocks the upstream stage.
  assign hold = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= res.valid | hold;
    end
    if (res.valid) begin
      concentration <= res.concentration;
      ready_toggle  <= res.ready_toggle;
    end
  end

endmodule

[hdl/sensor_frame_checksum_parser.sv]
`timescale 1ns / 1ps
// Nine-byte sensor frame parser with a two's complement checksum.
// Input channel: in_valid / in_stall carry rx_byte, one received serial byte
// per item. A 0xFF byte restarts a frame; bytes 1 to 7 are summed mod 256 and
// byte 8 must equal the negated sum.
// Output channel: out_valid / out_stall carry concentration (tenths of ppm)
// and ready_toggle, which inverts on every good frame. Bad frames give nothing.
// Config channel: cfg_valid / cfg_ready write answer_mode (0 active upload,
// value in bytes 4-5; 1 question-answer, bytes 2-3). Write it while idle.
// A good checksum byte steps from the input register into the result register.
// Throughput: one byte per cycle while no result is held, set by the input
// register feeding the parser state and result register in a single step.
// Reset (rst, synchronous): parser idles until a start byte, flag and mode
// clear, no result pending.
// Stall: a held result stops the input register; a new byte is still taken
// while that register is empty, so at most one byte waits behind a result.
module sensor_frame_checksum_parser import sfcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] concentration,
  output logic        ready_toggle,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        answer_mode
);

  logic         mode;
  logic         hold;
  logic         stage_full;
  sfcp_result_t res;

  // Take config only when no byte sits in the input register.
  assign cfg_ready = ~stage_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_UPLOAD;
    end else if (cfg_valid && cfg_ready) begin
      mode <= answer_mode;
    end
  end

  sfcp_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .rx_byte    (rx_byte),
    .answer_mode(mode),
    .hold       (hold),
    .in_stall   (in_stall),
    .stage_full (stage_full),
    .res        (res)
  );

  sfcp_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .concentration(concentration),
    .ready_toggle (ready_toggle),
    .hold         (hold)
  );

`ifndef SYNTHESIS
  // Never overwrite a result still held by the receiver.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !hold)
    else $error("result produced while output held");

  // Stall only when a byte really waits in the input register.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stage_full)
    else $error("input stalled with empty stage");

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !stage_full)
    else $error("pending item after reset");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import sfcp_pkg::*;

  localparam int CLK_HALF   = 6;
  localparam int RST_CYCLES = 7;
  localparam int LIMIT      = 200_000;
  // Cycles with nothing in flight before a mode write or the end of the run.
  localparam int SETTLE     = 4;
  localparam int DRAIN      = 8;
  // Planned items left when idling on both sides stops.
  localparam int TAIL       = 60;
  localparam int RANDOM_BYTES = 550;

  typedef struct {
    bit         is_mode;
    logic [7:0] data;
  } plan_item_t;

  typedef struct {
    logic [15:0] conc;
    logic        flag;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] concentration;
  logic        ready_toggle;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        answer_mode = MODE_UPLOAD;

  plan_item_t rx_plan[$];
  reading_t   reading_q[$];

  // Parser state as the bench sees it.
  logic [3:0] pos_m;
  logic [7:0] sum_m;
  logic [7:0] hi_m;
  logic [7:0] lo_m;
  logic       flag_m;
  logic       mode_m;

  int quiet_cycles = 0;
  int bad_count = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int calm_in = 0;
  int stall_left = 0;
  int calm_out = 0;

  sensor_frame_checksum_parser uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .concentration (concentration),
    .ready_toggle  (ready_toggle),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .answer_mode   (answer_mode)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
  end

  // Advance the parser by one accepted byte; queue a reading on a good checksum.
  task automatic track_byte(input logic [7:0] b);
    logic [3:0] hi_pos;
    logic [7:0] want;
    hi_pos = (mode_m == MODE_ANSWER) ? HI_POS_ANSWER : HI_POS_UPLOAD;
    want = 8'h00 - sum_m;
    if (b == START_BYTE) begin
      pos_m = FIRST_POS;
      sum_m = 8'h00;
    end else if (pos_m >= FIRST_POS && pos_m < LAST_POS) begin
      sum_m = sum_m + b;
      if (pos_m == hi_pos) hi_m = b;
      else if (pos_m == hi_pos + 4'd1) lo_m = b;
      pos_m = pos_m + 4'd1;
    end else if (pos_m == LAST_POS) begin
      pos_m = IDLE_POS;
      if (b == want) begin
        flag_m = ~flag_m;
        reading_q.push_back('{{hi_m, lo_m}, flag_m});
      end
    end
    // anything else arrives while idle: drop it
  endtask

  task automatic plan_byte(input logic [7:0] b);
    rx_plan.push_back('{1'b0, b});
  endtask

  task automatic plan_mode(input logic m);
    rx_plan.push_back('{1'b1, {7'd0, m}});
  endtask

  // Queue a full frame. switch_at names the data byte before which the mode
  // is rewritten (0 for none); a bad frame gets a wrong checksum.
  task automatic plan_frame(input logic [6:0][7:0] body, input bit good,
                            input int switch_at, input logic m);
    logic [7:0] sum;
    sum = 8'h00;
    plan_byte(START_BYTE);
    for (int i = 0; i < 7; i++) begin
      if (i + 1 == switch_at) plan_mode(m);
      plan_byte(body[i]);
      sum = sum + body[i];
    end
    sum = 8'h00 - sum;
    if (!good) sum = sum + 8'($urandom_range(1, 255));
    plan_byte(sum);
  endtask

  function automatic logic [6:0][7:0] rand_body();
    logic [6:0][7:0] body;
    for (int i = 0; i < 7; i++) begin
      // mostly clean data; now and then a start byte lands inside the frame
      if ($urandom_range(0, 39) == 0) body[i] = START_BYTE;
      else body[i] = 8'($urandom_range(0, 254));
    end
    return body;
  endfunction

  // Stimulus plan, then wait for the drain and report.
  initial begin
    int planned;
    int pick;
    int n;
    planned = 0;

    // Idle byte before any start byte is ignored.
    plan_byte(8'h00);
    // Start byte where a data byte is expected, then a frame with a bad checksum.
    plan_byte(START_BYTE);
    plan_byte(8'h05);
    plan_frame({8'h7F, 8'h80, 8'h01, 8'hFE, 8'h00, 8'h00, 8'h01}, 1'b0, 0, MODE_UPLOAD);
    // Question-answer frame with a switch back to upload in mid frame.
    plan_mode(MODE_ANSWER);
    plan_frame({8'h77, 8'h66, 8'h55, 8'h00, 8'hCD, 8'hAB, 8'h01}, 1'b1, 4, MODE_UPLOAD);
    // Sum of one: the right checksum is the start byte, which restarts instead.
    plan_frame({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b1, 0, MODE_UPLOAD);

    while (planned < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        plan_frame(rand_body(), $urandom_range(0, 7) != 0,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : 0,
                   1'($urandom_range(0, 1)));
        planned += 9;
      end else if (pick < 80) begin
        // truncated frame; the next start byte cuts it off
        n = $urandom_range(1, 7);
        plan_byte(START_BYTE);
        for (int i = 0; i < n; i++) plan_byte(8'($urandom_range(0, 254)));
        planned += n + 1;
      end else if (pick < 90) begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) plan_byte(8'($urandom_range(0, 255)));
        planned += n;
      end else begin
        plan_mode(1'($urandom_range(0, 1)));
      end
    end
    // Close on a frame planned with a good checksum, inside the quiet tail.
    plan_frame(rand_body(), 1'b1, 0, MODE_UPLOAD);

    do @(posedge clk);
    while (rst || rx_plan.size() != 0 || in_valid || cfg_valid || quiet_cycles < DRAIN);
    if (bad_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // Driver: feed bytes and mode writes from the plan, with random gaps.
  always @(posedge clk) begin
    logic held;
    plan_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      rx_byte <= 8'h00;
      answer_mode <= MODE_UPLOAD;
      gap_left = 0;
      calm_in = 0;
    end else begin
      // hold a stalled byte or an unanswered write as it is
      held = (in_valid && in_stall) || (cfg_valid && !cfg_ready);
      if (!held) begin
        if (calm_in > 0) calm_in--;
        else if ($urandom_range(0, 99) == 0) calm_in = $urandom_range(20, 120);
        if (gap_left > 0 || rx_plan.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
          cfg_valid <= 1'b0;
        end else if (rx_plan[0].is_mode) begin
          in_valid <= 1'b0;
          // write the mode only once the block has gone quiet
          if (quiet_cycles >= SETTLE) begin
            nxt = rx_plan.pop_front();
            cfg_valid <= 1'b1;
            answer_mode <= nxt.data[0];
          end else begin
            cfg_valid <= 1'b0;
          end
        end else begin
          nxt = rx_plan.pop_front();
          in_valid <= 1'b1;
          rx_byte <= nxt.data;
          cfg_valid <= 1'b0;
          if (calm_in == 0 && rx_plan.size() > TAIL && $urandom_range(0, 5) == 0)
            gap_left = $urandom_range(1, 16);
        end
      end
    end
  end

  // Monitor: check readings, track accepted bytes and mode writes, drive stall.
  always @(posedge clk) begin
    reading_t due;
    if (rst) begin
      pos_m = IDLE_POS;
      sum_m = 8'h00;
      hi_m = 8'h00;
      lo_m = 8'h00;
      flag_m = 1'b0;
      mode_m = MODE_UPLOAD;
      quiet_cycles = 0;
      stall_left = 0;
      calm_out = 0;
      out_stall <= 1'b0;
    end else begin
      // check first: a byte accepted at this edge cannot yield a reading yet
      if (out_valid && !out_stall) begin
        if (reading_q.size() == 0) begin
          $error("concentration: expected no reading, got %0d", concentration);
          bad_count++;
        end else begin
          due = reading_q.pop_front();
          if (concentration !== due.conc) begin
            $error("concentration: expected %0d, got %0d", due.conc, concentration);
            bad_count++;
          end
          if (ready_toggle !== due.flag) begin
            $error("ready_toggle: expected %0b, got %0b", due.flag, ready_toggle);
            bad_count++;
          end
        end
      end
      if (in_valid && !in_stall) track_byte(rx_byte);
      if (cfg_valid && cfg_ready) mode_m = answer_mode;

      if (in_valid || cfg_valid || out_valid || reading_q.size() != 0) quiet_cycles = 0;
      else quiet_cycles++;

      if (calm_out > 0) calm_out--;
      else if ($urandom_range(0, 99) == 0) calm_out = $urandom_range(20, 120);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (calm_out == 0 && rx_plan.size() > TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

endmodule
